### design/ptd_pkg.sv
// Shared types, codes and sizes for the periodic task dispatcher.
package ptd_pkg;

  // Table size default and command queue depth
  localparam int MAX_SLOTS_DEF = 8;
  localparam int FQ_DEPTH      = 4;

  // Configuration port
  localparam int              ADDR_W          = 3;
  localparam logic            REG_TICK_STEP   = 1'b0;
  localparam logic [7:0]      TICK_STEP_RESET = 8'd10;

  // Input op codes
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_ADD     = 3'd1;
  localparam logic [2:0] OP_ENABLE  = 3'd2;
  localparam logic [2:0] OP_DISABLE = 3'd3;
  localparam logic [2:0] OP_RUN     = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_DONE   = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_DUE    = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // Classified command handed from front to back
  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_ADD,
    CMD_ENABLE,
    CMD_DISABLE,
    CMD_RUN,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] period;
    logic        handler;
    logic [7:0]  slot;
  } cmd_t;

endpackage

### design/ptd_ifs.sv
// Valid/ready channel interfaces for request and result words.
interface ptd_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] task_period;
  logic        handler_present;
  logic [7:0]  slot_index;

  modport source(output valid, op, task_period, handler_present, slot_index, input ready);
  modport sink(input valid, op, task_period, handler_present, slot_index, output ready);
endinterface

interface ptd_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  task_id;
  logic [31:0] uptime_ms;
  logic        last;

  modport source(output valid, kind, task_id, uptime_ms, last, input ready);
  modport sink(input valid, kind, task_id, uptime_ms, last, output ready);
endinterface

### design/ptd_front.sv
// Front end: accepts request words and classifies them into queue commands.
module ptd_front
  import ptd_pkg::*;
(
  ptd_req_if.sink req,
  input  logic    q_full,
  output logic    q_push,
  output cmd_t    q_cmd
);

  // Take a word whenever the queue has room
  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;

  // Decode the op into a command
  always_comb begin
    q_cmd.period  = req.task_period;
    q_cmd.handler = req.handler_present;
    q_cmd.slot    = req.slot_index;
    case (req.op)
      OP_TICK:    q_cmd.kind = CMD_TICK;
      OP_ADD:     q_cmd.kind = CMD_ADD;
      OP_ENABLE:  q_cmd.kind = CMD_ENABLE;
      OP_DISABLE: q_cmd.kind = CMD_DISABLE;
      OP_RUN:     q_cmd.kind = CMD_RUN;
      default:    q_cmd.kind = CMD_BAD;
    endcase
  end

endmodule

### design/ptd_fifo.sv
// Short command queue between the front end and the execution unit.
module ptd_fifo
  import ptd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(FQ_DEPTH + 1);

  cmd_t             entries [FQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(FQ_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### design/ptd_back.sv
// Execution unit: task table, millisecond clock, slot scan and result register.
module ptd_back
  import ptd_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic [7:0] tick_step,
  input  logic q_valid,
  input  cmd_t q_data,
  output logic q_pop,
  output logic [$clog2(MAX_SLOTS+1)-1:0] slot_count,
  ptd_rsp_if.source rsp
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t               state, state_next;
  logic [31:0]          clock_ms, clock_next;
  logic [CNT_W-1:0]     slots_used, slots_next;
  logic [MAX_SLOTS-1:0] en_flags, en_next;
  logic [IDX_W-1:0]     idx, idx_next, idx_inc;
  logic                 pend_valid, pend_valid_next;
  logic [2:0]           pend_id, pend_id_next;

  // Task table memories
  logic [31:0]      period_mem [MAX_SLOTS];
  logic [31:0]      last_mem   [MAX_SLOTS];
  logic [31:0]      rd_period;
  logic [31:0]      rd_last;
  logic             per_we, lr_we;
  logic [IDX_W-1:0] waddr, raddr;

  // Result register
  logic        rsp_valid;
  logic [1:0]  rsp_kind;
  logic [2:0]  rsp_id;
  logic [31:0] rsp_uptime;
  logic        rsp_last;
  logic        out_free, out_load;
  logic [1:0]  o_kind;
  logic [2:0]  o_id;
  logic        o_last;

  // Scan and decode helpers
  logic [31:0] elapsed;
  logic        due, stall, scan_end, table_full, slot_ok;
  logic [7:0]  slots_w8, idx_w8;

  assign rsp.valid     = rsp_valid;
  assign rsp.kind      = rsp_kind;
  assign rsp.task_id   = rsp_id;
  assign rsp.uptime_ms = rsp_uptime;
  assign rsp.last      = rsp_last;
  assign slot_count    = slots_used;

  assign out_free   = !rsp_valid || rsp.ready;
  assign elapsed    = clock_ms - rd_last;
  assign due        = en_flags[idx] && (elapsed >= rd_period);
  assign stall      = due && pend_valid && !out_free;
  assign idx_inc    = idx + IDX_W'(1);
  assign scan_end   = (CNT_W'(idx) + CNT_W'(1)) == slots_used;
  assign table_full = slots_used >= CNT_W'(MAX_SLOTS);
  assign slots_w8   = 8'(slots_used);
  assign idx_w8     = 8'(idx);
  assign slot_ok    = q_data.slot < slots_w8;

  // Command execution and slot scan
  always_comb begin
    state_next      = state;
    clock_next      = clock_ms;
    slots_next      = slots_used;
    en_next         = en_flags;
    idx_next        = idx;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    out_load        = 1'b0;
    o_kind          = KIND_DONE;
    o_id            = '0;
    o_last          = 1'b1;
    q_pop           = 1'b0;
    per_we          = 1'b0;
    lr_we           = 1'b0;
    waddr           = slots_used[IDX_W-1:0];
    raddr           = '0;
    case (state)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_data.kind)
            CMD_TICK: begin
              clock_next = clock_ms + 32'(tick_step);
              out_load   = 1'b1;
            end
            CMD_ADD: begin
              out_load = 1'b1;
              if (table_full || !q_data.handler) begin
                o_kind = KIND_REJECT;
              end else begin
                per_we                          = 1'b1;
                lr_we                           = 1'b1;
                en_next[slots_used[IDX_W-1:0]]  = 1'b1;
                slots_next                      = slots_used + CNT_W'(1);
                o_id                            = slots_w8[2:0];
              end
            end
            CMD_ENABLE, CMD_DISABLE: begin
              out_load = 1'b1;
              if (slot_ok) begin
                en_next[q_data.slot[IDX_W-1:0]] = (q_data.kind == CMD_ENABLE);
                o_id                            = q_data.slot[2:0];
              end else begin
                o_kind = KIND_REJECT;
              end
            end
            CMD_RUN: begin
              idx_next        = '0;
              pend_valid_next = 1'b0;
              state_next      = (slots_used == '0) ? S_DONE : S_SCAN;
            end
            default: begin
              out_load = 1'b1;
              o_kind   = KIND_REJECT;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Hold one due slot back so the final one can carry last
        raddr = idx;
        if (!stall) begin
          if (due) begin
            lr_we           = 1'b1;
            waddr           = idx;
            pend_valid_next = 1'b1;
            pend_id_next    = idx_w8[2:0];
            if (pend_valid) begin
              out_load = 1'b1;
              o_kind   = KIND_DUE;
              o_id     = pend_id;
              o_last   = 1'b0;
            end
          end
          if (scan_end) begin
            state_next = S_DONE;
          end else begin
            idx_next = idx_inc;
            raddr    = idx_inc;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load        = 1'b1;
          o_kind          = pend_valid ? KIND_DUE : KIND_NONE;
          o_id            = pend_valid ? pend_id : 3'd0;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Table memories with registered read
  always_ff @(posedge clk) begin
    if (per_we) begin
      period_mem[waddr] <= q_data.period;
    end
    if (lr_we) begin
      last_mem[waddr] <= clock_ms;
    end
    rd_period <= period_mem[raddr];
    rd_last   <= last_mem[raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      clock_ms   <= '0;
      slots_used <= '0;
      en_flags   <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clock_ms   <= clock_next;
      slots_used <= slots_next;
      en_flags   <= en_next;
      pend_valid <= pend_valid_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Scan index and result payload
  always_ff @(posedge clk) begin
    idx     <= idx_next;
    pend_id <= pend_id_next;
    if (out_load) begin
      rsp_kind   <= o_kind;
      rsp_id     <= o_id;
      rsp_uptime <= clock_next;
      rsp_last   <= o_last;
    end
  end

endmodule

### design/periodic_task_dispatcher.sv
// A tick, add, enable, disable or unknown word gives its result word via the result register;
// a run word scans the registered slot count, one slot per cycle through the read port of the
// period and last-run memories while no due slot is stalled, then closes the scan. Throughput:
// one word per cycle into a 4-deep command queue while not full; execution of one at a time.
// Reset (synchronous, active high) clears the clock, slot count, enable flags and queue, and
// sets the tick step to 10; the period and last-run memories hold no value until written.
module periodic_task_dispatcher
  import ptd_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  ptd_req_if.sink           req,
  ptd_rsp_if.source         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  logic             q_push, q_full, q_pop, q_empty;
  cmd_t             q_in, q_out;
  logic [7:0]       tick_step;
  logic [CNT_W-1:0] slot_count;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_TICK_STEP) ? {24'd0, tick_step} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= TICK_STEP_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[ADDR_W-1:2] == REG_TICK_STEP) begin
      tick_step <= pwdata[7:0];
    end
  end

  ptd_front u_front (
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_in)
  );

  ptd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  ptd_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .tick_step  (tick_step),
    .q_valid    (!q_empty),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .slot_count (slot_count),
    .rsp        (rsp)
  );

  // Only due words may be followed by more words of the same item
  a_nondue_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.kind != KIND_DUE |-> rsp.last)
    else $error("non-due result word without last");

  // Slot count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    slot_count <= CNT_W'(MAX_SLOTS))
    else $error("slot count beyond table size");

  // Slot count only grows, one add at a time
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    slot_count != $past(slot_count) |-> slot_count == $past(slot_count) + CNT_W'(1))
    else $error("slot count changed by other than one add");

endmodule
